@@ hdl/trbs_pkg.sv @@
// ----------------------------------------------------------------------------
// trbs_pkg
// Shared types and constants of the fragment timestamp rebaser.
// ----------------------------------------------------------------------------
package trbs_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 63;
  localparam int unsigned FIELD_W  = 64;
  localparam int unsigned CNT_W    = 4;   // holds 0..8 bytes per group

  // Box type four-character codes
  localparam logic [31:0] KIND_SIDX = 32'h7369_6478;
  localparam logic [31:0] KIND_TFDT = 32'h7466_6474;
  localparam logic [31:0] KIND_MOOF = 32'h6d6f_6f66;
  localparam logic [31:0] KIND_TRAF = 32'h7472_6166;

  localparam logic [4:0] SIDX_FIELD_POS = 5'd20;
  localparam logic [4:0] TFDT_FIELD_POS = 5'd12;
  localparam logic [31:0] HDR_LEN       = 32'd8;

  // Output bytes produced by one input byte, first byte in the top lane
  typedef struct packed {
    logic [FIELD_W-1:0] data;
    logic [CNT_W-1:0]   cnt;
    logic               last;
    logic               err;
  } grp_t;

endpackage

@@ hdl/trbs_parser.sv @@
// ----------------------------------------------------------------------------
// trbs_parser
// Input register, box header walker and timestamp patch adder.
// ----------------------------------------------------------------------------
module trbs_parser import trbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [BYTE_W-1:0]   in_byte_i,
  input  logic                in_eof_i,
  input  logic                cfg_valid_i,
  input  logic [OFFSET_W-1:0] cfg_data_i,
  output grp_t                grp_o,
  output logic                grp_valid_o,
  input  logic                grp_ready_i
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PATCH,
    PH_ERROR
  } phase_e;

  logic                in_v_q;
  logic [BYTE_W-1:0]   byte_q;
  logic                eof_q;
  logic [OFFSET_W-1:0] offset_q;

  phase_e              phase_q, phase_d;
  logic [31:0]         size_q, size_d;
  logic [31:0]         pos_q, pos_d;
  logic [31:0]         kind_q, kind_d;
  logic [7:0]          ver_q, ver_d;
  logic [FIELD_W-1:0]  held_q, held_d;
  logic [2:0]          hcnt_q, hcnt_d;
  logic                err_q, err_d;

  logic                fire;
  grp_t                grp;

  assign fire        = in_v_q && grp_ready_i;
  assign in_ready_o  = !in_v_q || fire;
  assign grp_valid_o = in_v_q;
  assign grp_o       = grp;

  always_comb begin
    logic [31:0]        size_nx;
    logic [31:0]        kind_nx;
    logic [32:0]        pos_inc;
    logic               box_end;
    logic [4:0]         off;
    logic [3:0]         len;
    logic [5:0]         field_end;
    logic               in_field;
    logic [FIELD_W-1:0] held_nx;
    logic [3:0]         hcnt_nx;
    logic [FIELD_W-1:0] sum;
    logic [5:0]         sh;

    phase_d = phase_q;
    size_d  = size_q;
    pos_d   = pos_q;
    kind_d  = kind_q;
    ver_d   = ver_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    err_d   = err_q;

    grp.data = {byte_q, {(FIELD_W-BYTE_W){1'b0}}};
    grp.cnt  = CNT_W'(1);
    grp.last = 1'b0;
    grp.err  = 1'b0;

    size_nx   = (pos_q < 32'd4) ? {size_q[23:0], byte_q} : size_q;
    kind_nx   = (pos_q < 32'd4) ? kind_q : {kind_q[23:0], byte_q};
    pos_inc   = {1'b0, pos_q} + 33'd1;
    box_end   = pos_inc >= {1'b0, size_q};
    off       = (kind_q == KIND_SIDX) ? SIDX_FIELD_POS : TFDT_FIELD_POS;
    len       = 4'd0;
    field_end = 6'd0;
    in_field  = 1'b0;
    held_nx   = {held_q[FIELD_W-BYTE_W-1:0], byte_q};
    hcnt_nx   = {1'b0, hcnt_q} + 4'd1;
    sum       = held_nx + {1'b0, offset_q};
    sh        = 6'd0;

    case (phase_q)
      PH_HEADER: begin
        size_d = size_nx;
        kind_d = kind_nx;
        if (pos_q == 32'd7) begin
          if (size_nx < HDR_LEN) begin
            err_d   = 1'b1;
            phase_d = PH_ERROR;
          end else if (kind_nx == KIND_MOOF || kind_nx == KIND_TRAF || size_nx == HDR_LEN) begin
            // containers are entered, empty boxes end right here
            pos_d  = '0;
            size_d = '0;
            kind_d = '0;
          end else begin
            phase_d = (kind_nx == KIND_SIDX || kind_nx == KIND_TFDT) ? PH_PATCH : PH_SKIP;
            pos_d   = HDR_LEN;
          end
        end else begin
          pos_d = pos_inc[31:0];
        end
      end
      PH_SKIP: begin
        if (box_end) begin
          phase_d = PH_HEADER;
          pos_d   = '0;
          size_d  = '0;
          kind_d  = '0;
        end else begin
          pos_d = pos_inc[31:0];
        end
      end
      PH_PATCH: begin
        if (pos_q == HDR_LEN) begin
          ver_d = byte_q;
        end
        if (pos_q > HDR_LEN) begin
          if (ver_q == 8'd1) begin
            len = 4'd8;
          end else if (ver_q == 8'd0) begin
            len = 4'd4;
          end
          // box too short to hold the whole field
          if (size_q < 32'({1'b0, off} + {2'b0, len})) begin
            len = 4'd0;
          end
        end
        field_end = {1'b0, off} + {2'b0, len};
        in_field  = (len != 4'd0) && (pos_q >= 32'(off)) && (pos_q < 32'(field_end));
        if (in_field) begin
          if (hcnt_nx == len) begin
            grp.cnt  = len;
            grp.data = (len == 4'd8) ? sum : {sum[31:0], 32'd0};
            held_d   = '0;
            hcnt_d   = '0;
          end else begin
            grp.cnt = '0;
            held_d  = held_nx;
            hcnt_d  = hcnt_nx[2:0];
          end
        end
        if (box_end) begin
          phase_d = PH_HEADER;
          pos_d   = '0;
          size_d  = '0;
          kind_d  = '0;
        end else begin
          pos_d = pos_inc[31:0];
        end
      end
      PH_ERROR: begin
        // pass through until the end of the fragment
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase

    grp.err = err_d;

    if (eof_q) begin
      // held bytes go out unpatched; nothing else is emitted for a held byte
      if (hcnt_d != 3'd0) begin
        sh       = {(4'd8 - {1'b0, hcnt_d}), 2'b00} << 1;
        grp.data = held_d << sh;
        grp.cnt  = {1'b0, hcnt_d};
      end
      grp.last = 1'b1;
      phase_d  = PH_HEADER;
      size_d   = '0;
      pos_d    = '0;
      kind_d   = '0;
      ver_d    = '0;
      held_d   = '0;
      hcnt_d   = '0;
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      offset_q <= '0;
      phase_q  <= PH_HEADER;
      size_q   <= '0;
      pos_q    <= '0;
      kind_q   <= '0;
      ver_q    <= '0;
      held_q   <= '0;
      hcnt_q   <= '0;
      err_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        offset_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        size_q  <= size_d;
        pos_q   <= pos_d;
        kind_q  <= kind_d;
        ver_q   <= ver_d;
        held_q  <= held_d;
        hcnt_q  <= hcnt_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      eof_q  <= in_eof_i;
    end
  end

  a_error_phase_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |-> err_q)
    else $error("error phase without error flag");

  a_held_only_in_patch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q != 3'd0 |-> phase_q == PH_PATCH)
    else $error("bytes held outside a patched box");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && eof_q |=> phase_q == PH_HEADER && hcnt_q == 3'd0 && !err_q)
    else $error("parse state not cleared after end of fragment");

endmodule

@@ hdl/trbs_out_buf.sv @@
// ----------------------------------------------------------------------------
// trbs_out_buf
// Result register: holds one byte group and sends it a byte per transaction.
// ----------------------------------------------------------------------------
module trbs_out_buf import trbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grp_t              grp_i,
  input  logic              grp_valid_i,
  output logic              grp_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o,
  output logic              out_err_o
);

  logic [FIELD_W-1:0] data_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               last_q;
  logic               err_q;
  logic               xfer;
  logic               load;

  assign xfer        = out_valid_o && out_ready_i;
  assign grp_ready_o = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_ready_i)
                       || (grp_i.cnt == '0);
  assign load        = grp_valid_i && grp_ready_o && (grp_i.cnt != '0);

  assign out_valid_o = cnt_q != '0;
  assign out_byte_o  = data_q[FIELD_W-1 -: BYTE_W];
  assign out_last_o  = last_q && (cnt_q == CNT_W'(1));
  assign out_err_o   = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= grp_i.cnt;
    end else if (xfer) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= grp_i.data;
      last_q <= grp_i.last;
      err_q  <= grp_i.err;
    end else if (xfer) begin
      data_q <= data_q << BYTE_W;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(8))
    else $error("output group count out of range");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> cnt_q == '0 || (cnt_q == CNT_W'(1) && xfer))
    else $error("group loaded over unsent bytes");

endmodule

@@ hdl/mp4_fragment_timestamp_rebaser_core.sv @@
// ----------------------------------------------------------------------------
// mp4_fragment_timestamp_rebaser_core
// Adds a timestamp offset to sidx and tfdt boxes of an MP4 fragment stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the fragment one byte per transaction, tlast on its final
//   byte. m_axis returns the same bytes in order; the timestamp field of sidx
//   (presentation time) and tfdt (decode time) comes out with time_offset
//   added, wrapping at the field width (32 or 64 bits by box version). tuser
//   flags a box size below 8 in the current fragment.
//   cfg_* writes time_offset; write it only while the block is idle.
// Timing:
//   One byte per cycle outside patched fields while m_axis_tready is high. A
//   byte accepted passes the input register and the parse/add logic, is
//   loaded into the output register and leaves m_axis from there.
//   Field bytes are held until the field is complete, then leave as a burst of
//   4 or 8 bytes from the output register, one per cycle while m_axis_tready
//   is high; s_axis stalls while the burst drains.
// Reset and stalls:
//   Reset clears the parse state and sets time_offset to 0. When m_axis_tready
//   is low the output register holds one byte or one burst, the input
//   register one more byte and the parser any field bytes still held, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module mp4_fragment_timestamp_rebaser_core import trbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // end_of_fragment
  // master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] out_byte
  output logic                m_axis_tlast,   // last_out
  output logic                m_axis_tuser,   // [0] box_error
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [OFFSET_W-1:0] cfg_data_i      // time_offset
);

  grp_t grp;
  logic grp_valid;
  logic grp_ready;

  assign cfg_ready_o = 1'b1;

  trbs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eof_i    (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .grp_o       (grp),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready)
  );

  trbs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule
